/* rtl/timer_queue_scheduler_assert.svh */
// Assertion macros for the timer queue scheduler checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef TIMER_QUEUE_SCHEDULER_ASSERT_SVH
`define TIMER_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define TQS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TQS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tqs_pkg.sv */
// Shared types and constants for the timer queue scheduler.
// No dependencies.
package tqs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int DW          = 32;
    localparam logic [DW-1:0] DELAY_NONE = '1;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_EXPIRED   = 3'd1,
        KIND_NONE      = 3'd2,
        KIND_REMOVED   = 3'd3,
        KIND_NOTFOUND  = 3'd4,
        KIND_NEXTDELAY = 3'd5,
        KIND_FULL      = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        SC_NONE,
        SC_TICK,
        SC_MATCH,
        SC_MIN,
        SC_RELOAD
    } t_scan;

    typedef struct packed {
        logic  load_in;
        logic  scan_start;
        t_scan scan_mode;
        logic  tick_now;
        logic  fire;
        logic  add_commit;
        logic  rm_commit;
        logic  out_load;
        t_kind out_kind;
        logic  out_last;
    } t_cmd;

    typedef struct packed {
        logic idx_end;
        logic best_vld;
        logic full;
        logic cnt_zero;
        logic cnt_pre_full;
        logic out_free;
    } t_sts;

endpackage

/* rtl/tqs_dp.sv */
// Datapath: timer table, scan index, best-entry tracking, result register.
// Depends on tqs_pkg.
module tqs_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tqs_pkg::t_cmd        i_cmd,
    output tqs_pkg::t_sts        o_sts,
    input  logic [31:0]          i_interval,
    input  logic                 i_rep,
    input  logic [31:0]          i_tgt,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [2:0]           o_kind,
    output logic [31:0]          o_ident,
    output logic [31:0]          o_delay,
    output logic                 o_last
);
    import tqs_pkg::*;

    logic [TABLE_DEPTH-1:0] r_vld;
    logic [TABLE_DEPTH-1:0] r_fired;
    logic [DW-1:0]          r_id  [TABLE_DEPTH];
    logic [DW-1:0]          r_dl  [TABLE_DEPTH];
    logic [DW-1:0]          r_per [TABLE_DEPTH];
    logic                   r_rep [TABLE_DEPTH];
    logic [DW-1:0]          r_now;
    logic [DW-1:0]          r_last_id;
    logic [DW-1:0]          r_ival;
    logic                   r_rep_in;
    logic [DW-1:0]          r_tgt;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_best_vld;
    logic [IDX_W-1:0]       r_best_idx;
    logic [DW-1:0]          r_best_dl;
    logic [DW-1:0]          r_best_id;
    logic [DW-1:0]          r_pend_id;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_vld;
    t_kind                  r_kind;
    logic [DW-1:0]          r_ident;
    logic [DW-1:0]          r_delay;
    logic                   r_last;

    logic             c_vld;
    logic [DW-1:0]    c_dl;
    logic [DW-1:0]    c_id;
    logic             hit;
    logic [IDX_W-1:0] free_idx;
    logic [DW-1:0]    n_id;
    logic [DW-1:0]    q_delay;
    logic [DW-1:0]    n_ident;
    logic [DW-1:0]    n_delay;
    logic             out_free;

    always_comb begin
        c_vld = r_vld[r_idx];
        c_dl  = r_dl[r_idx];
        c_id  = r_id[r_idx];
        case (i_cmd.scan_mode)
            SC_TICK:  hit = c_vld && !r_fired[r_idx] && (c_dl < r_now) &&
                            (!r_best_vld || (c_dl < r_best_dl) ||
                             ((c_dl == r_best_dl) && (c_id < r_best_id)));
            SC_MATCH: hit = c_vld && (c_id == r_tgt) && !r_best_vld;
            SC_MIN:   hit = c_vld && (!r_best_vld || (c_dl < r_best_dl));
            default:  hit = 1'b0;
        endcase
    end

    always_comb begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_vld[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_id = r_last_id + 32'd1;
        if (n_id == '0) begin
            n_id = 32'd1;
        end
        if (!r_best_vld) begin
            q_delay = DELAY_NONE;
        end else if (r_best_dl <= r_now) begin
            q_delay = '0;
        end else begin
            q_delay = r_best_dl - r_now;
        end
        n_ident = '0;
        n_delay = '0;
        case (i_cmd.out_kind)
            KIND_ADDED:     n_ident = n_id;
            KIND_EXPIRED:   n_ident = r_pend_id;
            KIND_REMOVED:   n_ident = r_tgt;
            KIND_NEXTDELAY: n_delay = q_delay;
            default:        n_ident = '0;
        endcase
    end

    assign out_free = !r_out_vld || i_m_tready;

    always_comb begin
        o_sts.idx_end      = (r_idx == IDX_W'(TABLE_DEPTH - 1));
        o_sts.best_vld     = r_best_vld;
        o_sts.full         = &r_vld;
        o_sts.cnt_zero     = (r_cnt == '0);
        o_sts.cnt_pre_full = (r_cnt == CNT_W'(MAX_RESULTS - 1));
        o_sts.out_free     = out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_fired    <= '0;
            r_now      <= '0;
            r_last_id  <= '0;
            r_idx      <= '0;
            r_best_vld <= 1'b0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.scan_mode != SC_NONE) begin
                r_idx <= r_idx + 1'b1;
                if (hit) begin
                    r_best_vld <= 1'b1;
                end
                if (i_cmd.scan_mode == SC_RELOAD && r_fired[r_idx] && !r_rep[r_idx]) begin
                    r_vld[r_idx] <= 1'b0;
                end
            end
            if (i_cmd.scan_start) begin
                r_idx      <= '0;
                r_best_vld <= 1'b0;
            end
            if (i_cmd.tick_now) begin
                r_now   <= r_now + 32'd1;
                r_fired <= '0;
                r_cnt   <= '0;
            end
            if (i_cmd.fire) begin
                r_fired[r_best_idx] <= 1'b1;
                r_cnt               <= r_cnt + 1'b1;
            end
            if (i_cmd.add_commit) begin
                r_vld[free_idx] <= 1'b1;
                r_last_id       <= n_id;
            end
            if (i_cmd.rm_commit) begin
                r_vld[r_best_idx] <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ival   <= i_interval;
            r_rep_in <= i_rep;
            r_tgt    <= i_tgt;
        end
        if (hit) begin
            r_best_idx <= r_idx;
            r_best_dl  <= c_dl;
            r_best_id  <= c_id;
        end
        if (i_cmd.scan_mode == SC_RELOAD && r_fired[r_idx] && r_rep[r_idx]) begin
            r_dl[r_idx] <= r_now + r_per[r_idx];
        end
        if (i_cmd.fire) begin
            r_pend_id <= r_best_id;
        end
        if (i_cmd.add_commit) begin
            r_id[free_idx]  <= n_id;
            r_per[free_idx] <= r_ival;
            r_dl[free_idx]  <= r_now + r_ival;
            r_rep[free_idx] <= r_rep_in;
        end
        if (i_cmd.out_load) begin
            r_kind  <= i_cmd.out_kind;
            r_ident <= n_ident;
            r_delay <= n_delay;
            r_last  <= i_cmd.out_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_kind     = r_kind;
    assign o_ident    = r_ident;
    assign o_delay    = r_delay;
    assign o_last     = r_last;

endmodule

/* rtl/tqs_ctrl.sv */
// Controller: sequences ticks, adds, removes and queries over the table.
// Depends on tqs_pkg.
module tqs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_op,
    output logic           o_in_ready,
    input  tqs_pkg::t_sts  i_sts,
    output tqs_pkg::t_cmd  o_cmd
);
    import tqs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TSCAN,
        S_TDEC,
        S_TLAST,
        S_TRELOAD,
        S_ADD,
        S_RSCAN,
        S_RFIN,
        S_QSCAN,
        S_QFIN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    unique case (t_op'(i_op))
                        OP_TICK: begin
                            o_cmd.tick_now = 1'b1;
                            n_state        = S_TSCAN;
                        end
                        OP_ADD:    n_state = S_ADD;
                        OP_REMOVE: n_state = S_RSCAN;
                        OP_QUERY:  n_state = S_QSCAN;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_TSCAN: begin
                o_cmd.scan_mode = SC_TICK;
                if (i_sts.idx_end) begin
                    n_state = S_TDEC;
                end
            end
            S_TDEC: begin
                if (i_sts.best_vld) begin
                    if (i_sts.cnt_zero || i_sts.out_free) begin
                        o_cmd.out_load = !i_sts.cnt_zero;
                        o_cmd.out_kind = KIND_EXPIRED;
                        o_cmd.fire     = 1'b1;
                        if (i_sts.cnt_pre_full) begin
                            n_state = S_TLAST;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_TSCAN;
                        end
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = i_sts.cnt_zero ? KIND_NONE : KIND_EXPIRED;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_TRELOAD;
                end
            end
            S_TLAST: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_kind   = KIND_EXPIRED;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_TRELOAD;
                end
            end
            S_TRELOAD: begin
                o_cmd.scan_mode = SC_RELOAD;
                if (i_sts.idx_end) begin
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_kind   = i_sts.full ? KIND_FULL : KIND_ADDED;
                    o_cmd.add_commit = !i_sts.full;
                    n_state          = S_IDLE;
                end
            end
            S_RSCAN: begin
                o_cmd.scan_mode = SC_MATCH;
                if (i_sts.idx_end) begin
                    n_state = S_RFIN;
                end
            end
            S_RFIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_last  = 1'b1;
                    o_cmd.out_kind  = i_sts.best_vld ? KIND_REMOVED : KIND_NOTFOUND;
                    o_cmd.rm_commit = i_sts.best_vld;
                    n_state         = S_IDLE;
                end
            end
            S_QSCAN: begin
                o_cmd.scan_mode = SC_MIN;
                if (i_sts.idx_end) begin
                    n_state = S_QFIN;
                end
            end
            S_QFIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.out_kind = KIND_NEXTDELAY;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/timer_queue_scheduler.sv */
// Channel | dir | tdata                                   | tuser     | tlast
// s       | in  | interval_ms, repeat_req, target_id      | opcode    | -
// m       | out | timer_ident, delay_ms                   | kind      | last
// Remove, query: one full table scan (one table entry per cycle).
// Tick: one table scan per expiry, one more that finds none unless 16 fired,
// then a reload sweep over the table. One op at a time.
// A stalled output holds the controller at its next beat; reset is synchronous.
// Top level; depends on tqs_pkg, tqs_ctrl, tqs_dp.
module timer_queue_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // interval_ms[31:0], repeat_req[32], target_id[64:33]
    input  logic [1:0]  i_s_tuser,  // opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,  // timer_ident[31:0], delay_ms[63:32]
    output logic [2:0]  o_m_tuser,  // kind
    output logic        o_m_tlast
);
    import tqs_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] ident;
    logic [31:0] delay;

    tqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tqs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_interval (i_s_tdata[31:0]),
        .i_rep      (i_s_tdata[32]),
        .i_tgt      (i_s_tdata[64:33]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_kind     (o_m_tuser),
        .o_ident    (ident),
        .o_delay    (delay),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {delay, ident};

endmodule

/* rtl/tqs_checker.sv */
// Port-level checks for timer_queue_scheduler, bound to the top level.
// Depends on tqs_pkg and timer_queue_scheduler_assert.svh.
`include "timer_queue_scheduler_assert.svh"
module tqs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);
    import tqs_pkg::*;

    `TQS_ASSERT_NXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "beat dropped while stalled")
    `TQS_ASSERT_IMP(a_add_id, o_m_tvalid && o_m_tuser == KIND_ADDED, o_m_tdata[31:0] != '0, "zero id")
    `TQS_ASSERT_IMP(a_single, o_m_tvalid && o_m_tuser != KIND_EXPIRED, o_m_tlast, "single beat not last")
    `TQS_ASSERT_IMP(a_delay0, o_m_tvalid && o_m_tuser != KIND_NEXTDELAY, o_m_tdata[63:32] == '0, "delay set")

endmodule

bind timer_queue_scheduler tqs_checker u_tqs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

/* dv/timer_queue_scheduler_tb.sv */
// Self-checking bench for timer_queue_scheduler: drives add, remove, query and tick beats
// through the stream ports and checks every result beat against an in-bench timer table.
// Depends on tqs_pkg and the timer_queue_scheduler RTL.
`timescale 1ns / 1ps

module timer_queue_scheduler_tb;
    import tqs_pkg::*;

    localparam int DEPTH = 16;
    localparam int MAXEXP = 16;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        t_op         op;
        logic [31:0] interval;
        logic        rep;
        logic [31:0] target;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] ident;
        logic [31:0] delay;
        logic        last;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    timer_queue_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    // timer table mirror
    logic        tm_valid [DEPTH];
    logic [31:0] tm_ident [DEPTH];
    logic [31:0] tm_deadline [DEPTH];
    logic [31:0] tm_period [DEPTH];
    logic        tm_repeat [DEPTH];
    logic [31:0] clock_ms;
    logic [31:0] issued_id;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   error_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_send;
    bit   stim_done;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void enqueue_req(t_req q);
        pending_reqs = {pending_reqs, q};
    endfunction

    function automatic void push_res(t_kind k, logic [31:0] id, logic [31:0] d, logic l);
        t_res r;
        r.kind = k;
        r.ident = id;
        r.delay = d;
        r.last = l;
        expected_results = {expected_results, r};
    endfunction

    task automatic predict_timer_op(input t_req q);
        logic fired [DEPTH];
        int n;
        int best;
        int hit;
        logic any;
        logic [31:0] earliest;
        logic [31:0] d;
        n = 0;
        hit = -1;
        any = 0;
        earliest = 0;
        case (q.op)
            OP_TICK: begin
                foreach (fired[i]) fired[i] = 0;
                clock_ms = clock_ms + 1;
                while (n < MAXEXP) begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!tm_valid[i] || fired[i] || tm_deadline[i] >= clock_ms) continue;
                        if (best < 0 || tm_deadline[i] < tm_deadline[best] ||
                            (tm_deadline[i] == tm_deadline[best] &&
                             tm_ident[i] < tm_ident[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    fired[best] = 1;
                    push_res(KIND_EXPIRED, tm_ident[best], 0, 0);
                    n++;
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (!fired[i]) continue;
                    if (tm_repeat[i]) tm_deadline[i] = clock_ms + tm_period[i];
                    else tm_valid[i] = 0;
                end
                if (n == 0) push_res(KIND_NONE, 0, 0, 1);
                else expected_results[$].last = 1;
            end
            OP_ADD: begin
                for (int i = 0; i < DEPTH; i++)
                    if (!tm_valid[i] && hit < 0) hit = i;
                if (hit < 0) begin
                    push_res(KIND_FULL, 0, 0, 1);
                end else begin
                    issued_id = issued_id + 1;
                    if (issued_id == 0) issued_id = 1;
                    tm_valid[hit] = 1;
                    tm_ident[hit] = issued_id;
                    tm_period[hit] = q.interval;
                    tm_deadline[hit] = clock_ms + q.interval;
                    tm_repeat[hit] = q.rep;
                    push_res(KIND_ADDED, issued_id, 0, 1);
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < DEPTH; i++)
                    if (tm_valid[i] && tm_ident[i] == q.target && hit < 0) hit = i;
                if (hit < 0) begin
                    push_res(KIND_NOTFOUND, 0, 0, 1);
                end else begin
                    tm_valid[hit] = 0;
                    push_res(KIND_REMOVED, q.target, 0, 1);
                end
            end
            default: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!tm_valid[i]) continue;
                    if (!any || tm_deadline[i] < earliest) earliest = tm_deadline[i];
                    any = 1;
                end
                if (!any) d = '1;
                else if (earliest <= clock_ms) d = 0;
                else d = earliest - clock_ms;
                push_res(KIND_NEXTDELAY, 0, d, 1);
            end
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        t_req q;
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) predict_timer_op(pending_reqs.pop_front());
            if ((!i_s_tvalid || o_s_tready) ) begin
                if (pending_reqs.size() > (i_s_tvalid && o_s_tready ? 0 : 0) && !hold_send &&
                    !(i_s_tvalid && o_s_tready && pending_reqs.size() == 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    q = pending_reqs[0];
                    i_s_tvalid <= 1;
                    i_s_tdata <= {7'd0, q.target, q.rep, q.interval};
                    i_s_tuser <= q.op;
                end else begin
                    i_s_tvalid <= 0;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind=%0d", o_m_tuser));
            end else begin
                e = expected_results.pop_front();
                if (o_m_tuser != e.kind)
                    report_mismatch($sformatf("kind %0d exp %0d", o_m_tuser, e.kind));
                if (o_m_tdata[31:0] != e.ident)
                    report_mismatch($sformatf("ident %0h exp %0h", o_m_tdata[31:0], e.ident));
                if (o_m_tdata[63:32] != e.delay)
                    report_mismatch($sformatf("delay %0h exp %0h", o_m_tdata[63:32], e.delay));
                if (o_m_tlast != e.last)
                    report_mismatch($sformatf("last %0b exp %0b", o_m_tlast, e.last));
            end
        end
    end

    // watchdog
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("timer_queue_scheduler_tb: errors");
            $finish;
        end
    end

    function automatic t_req mk(t_op op, logic [31:0] iv, logic rp, logic [31:0] tg);
        t_req q;
        q.op = op;
        q.interval = iv;
        q.rep = rp;
        q.target = tg;
        return q;
    endfunction

    function automatic logic [31:0] rand_word();
        return $urandom();
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_phase(input int n, input int sidle, input int rstall);
        int r;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 35)
                enqueue_req(mk(OP_ADD, $urandom_range(9) < 7 ?
                    $urandom_range(12) : rand_word(), $urandom_range(1), rand_word()));
            else if (r < 70)
                enqueue_req(mk(OP_TICK, rand_word(), $urandom_range(1), rand_word()));
            else if (r < 85)
                enqueue_req(mk(OP_REMOVE, rand_word(), $urandom_range(1),
                    $urandom_range(3) == 0 ? rand_word() : issued_id - $urandom_range(6)));
            else
                enqueue_req(mk(OP_QUERY, rand_word(), $urandom_range(1), rand_word()));
        end
        wait_drained();
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        hold_send = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 0;
        foreach (tm_valid[i]) begin
            tm_valid[i] = 0;
            tm_ident[i] = 0;
            tm_deadline[i] = 0;
            tm_period[i] = 0;
            tm_repeat[i] = 0;
        end
        clock_ms = 0;
        issued_id = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty query, empty tick, a remove miss, fill, overflow, mass expiry
        enqueue_req(mk(OP_QUERY, '1, 1, '1));
        enqueue_req(mk(OP_TICK, '0, 0, '0));
        enqueue_req(mk(OP_REMOVE, '1, 1, '0));
        enqueue_req(mk(OP_ADD, 32'hffff_ffff, 1, '1));
        enqueue_req(mk(OP_ADD, 0, 1, 0));
        for (int k = 0; k < 14; k++) enqueue_req(mk(OP_ADD, 0, k[0], 0));
        enqueue_req(mk(OP_ADD, 5, 0, 0));
        enqueue_req(mk(OP_QUERY, 0, 0, 0));
        enqueue_req(mk(OP_TICK, 0, 0, 0));
        enqueue_req(mk(OP_REMOVE, 0, 0, 1));
        enqueue_req(mk(OP_REMOVE, 0, 0, 2));
        enqueue_req(mk(OP_TICK, 0, 0, 0));
        wait_drained();

        random_phase(30, 0, 0);
        random_phase(30, 80, 0);
        random_phase(30, 0, 80);
        random_phase(30, 21, 21);

        // sender is held off with a query pending, then released
        hold_send = 1;
        enqueue_req(mk(OP_QUERY, 0, 0, 0));
        repeat (5) @(posedge i_clk);
        hold_send = 0;
        wait_drained();
        random_phase(10, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("timer_queue_scheduler_tb: clean");
        end else begin
            $display("timer_queue_scheduler_tb: errors");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/tqs_pkg.sv
rtl/tqs_dp.sv
rtl/tqs_ctrl.sv
rtl/timer_queue_scheduler.sv
rtl/tqs_checker.sv
dv/timer_queue_scheduler_tb.sv
